FILE: src/hwrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwrg_pkg
// Shared constants and types for the hue wheel color generator.
// ----------------------------------------------------------------------------
package hwrg_pkg;

    localparam int TIME_W    = 16;
    localparam int CYC_W     = 16;
    localparam int LEVEL_W   = 8;
    localparam int RAMP_W    = 12;
    localparam int SEC_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam int COUNT_WIDTH_DEF        = 16;
    localparam int STROBE_HALF_PERIOD_DEF = 3;

    localparam int LEVEL_MAX   = 255;
    localparam int SECTIONS    = 6;
    localparam int CYCLE_MIN   = 6;
    localparam int CYCLE_RESET = 4096;
    localparam int SEC_RESET   = CYCLE_RESET / SECTIONS;

    // cycle / 6 as multiply and shift, exact for any 16-bit cycle
    localparam int SEC_RECIP = 43691;
    localparam int SEC_SHIFT = 18;

    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LENGTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STROBE_ENABLE = CFG_IDX_W'(1);

    // sections: full channel, then the ramping one
    localparam logic [SEC_W-1:0] SEC_RG = SEC_W'(0);
    localparam logic [SEC_W-1:0] SEC_GR = SEC_W'(1);
    localparam logic [SEC_W-1:0] SEC_GB = SEC_W'(2);
    localparam logic [SEC_W-1:0] SEC_BG = SEC_W'(3);
    localparam logic [SEC_W-1:0] SEC_BR = SEC_W'(4);
    localparam logic [SEC_W-1:0] SEC_RB = SEC_W'(5);

    typedef struct packed {
        logic              lit;
        logic [RAMP_W-1:0] ramp_base;
    } color_req_t;

endpackage

FILE: src/hue_wheel_rgb_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hue_wheel_rgb_generator
// Six-sector saturated hue wheel: time count in, red/green/blue levels out.
// ----------------------------------------------------------------------------
//  channel  | ports                        | word
//  ---------+------------------------------+------------------------------
//  input    | s_valid s_ready              | s_time_count
//  result   | m_valid m_ready              | m_red/green/blue_level
//  config   | cfg_valid cfg_ready          | cfg_index cfg_data
//
//  One word per cycle in while m_ready holds; each word passes through the
//  modulo cell row (one cell per count bit), two scale stages, the
//  12-cell ramp divide row and the output register.
//  Every stage stalls only when it holds a word the next one cannot take.
//  Reset: cycle length 4096, strobe off, all stages empty.
// ----------------------------------------------------------------------------
module hue_wheel_rgb_generator
    import hwrg_pkg::*;
#(
    parameter int COUNT_WIDTH        = COUNT_WIDTH_DEF,
    parameter int STROBE_HALF_PERIOD = STROBE_HALF_PERIOD_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [TIME_W-1:0]    s_time_count,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [LEVEL_W-1:0]   m_red_level,
    output logic [LEVEL_W-1:0]   m_green_level,
    output logic [LEVEL_W-1:0]   m_blue_level,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int CNT_W = (COUNT_WIDTH < TIME_W) ? COUNT_WIDTH : TIME_W;
    localparam int DVD_W = CNT_W + 8;
    localparam int ACC_B = RAMP_W + 1;

    logic [CYC_W-1:0] cyc_reg, cyc_w;
    logic [CYC_W-1:0] sec_reg;
    logic             strobe_reg;
    logic [31:0]      sec_prod;

    assign cfg_ready = 1'b1;

    always_comb begin
        cyc_w    = (cfg_data < CYC_W'(CYCLE_MIN)) ? CYC_W'(CYCLE_MIN) : cfg_data;
        sec_prod = 32'(cyc_w) * 32'(SEC_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cyc_reg    <= CYC_W'(CYCLE_RESET);
            sec_reg    <= CYC_W'(SEC_RESET);
            strobe_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CYCLE_LENGTH: begin
                    cyc_reg <= cyc_w;
                    sec_reg <= CYC_W'(sec_prod >> SEC_SHIFT);
                end
                REG_STROBE_ENABLE: begin
                    strobe_reg <= cfg_data[0];
                end
                default: ;
            endcase
        end
    end

    // position = count mod cycle
    logic             a_valid [CNT_W+1];
    logic             a_ready [CNT_W+1];
    logic [CNT_W-1:0] a_rem   [CNT_W+1];
    logic [1:0]       a_acc   [CNT_W+1];

    assign a_valid[0] = s_valid;
    assign s_ready    = a_ready[0];
    assign a_rem[0]   = s_time_count[CNT_W-1:0];
    assign a_acc[0]   = 2'b00;

    for (genvar i = 0; i < CNT_W; i++) begin : g_mod
        hwrg_div_cell #(
            .REM_W(CNT_W), .DIV_W(CYC_W), .ACC_W(2), .SHIFT(CNT_W - 1 - i)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .in_valid(a_valid[i]), .in_ready(a_ready[i]),
            .in_rem(a_rem[i]), .in_acc(a_acc[i]), .divisor(cyc_reg),
            .out_valid(a_valid[i+1]), .out_ready(a_ready[i+1]),
            .out_rem(a_rem[i+1]), .out_acc(a_acc[i+1])
        );
    end

    // ramp base = 255 * position / section
    logic             b_valid [RAMP_W+1];
    logic             b_ready [RAMP_W+1];
    logic [DVD_W-1:0] b_rem   [RAMP_W+1];
    logic [ACC_B-1:0] b_acc   [RAMP_W+1];
    logic             scale_lit;

    hwrg_scale_stage #(
        .POS_W(CNT_W), .STROBE_HALF_PERIOD(STROBE_HALF_PERIOD)
    ) u_scale (
        .aclk(aclk), .aresetn(aresetn), .strobe_en(strobe_reg),
        .in_valid(a_valid[CNT_W]), .in_ready(a_ready[CNT_W]), .in_pos(a_rem[CNT_W]),
        .out_valid(b_valid[0]), .out_ready(b_ready[0]),
        .out_dividend(b_rem[0]), .out_lit(scale_lit)
    );

    assign b_acc[0] = {RAMP_W'(0), scale_lit};

    for (genvar j = 0; j < RAMP_W; j++) begin : g_ramp
        hwrg_div_cell #(
            .REM_W(DVD_W), .DIV_W(CYC_W), .ACC_W(ACC_B), .SHIFT(RAMP_W - 1 - j)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .in_valid(b_valid[j]), .in_ready(b_ready[j]),
            .in_rem(b_rem[j]), .in_acc(b_acc[j]), .divisor(sec_reg),
            .out_valid(b_valid[j+1]), .out_ready(b_ready[j+1]),
            .out_rem(b_rem[j+1]), .out_acc(b_acc[j+1])
        );
    end

    color_req_t req;
    logic [DVD_W-1:0] ramp_rem;

    assign req.lit       = b_acc[RAMP_W][RAMP_W];
    assign req.ramp_base = b_acc[RAMP_W][RAMP_W-1:0];
    assign ramp_rem      = b_rem[RAMP_W];

    hwrg_color_stage u_color (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(b_valid[RAMP_W]), .in_ready(b_ready[RAMP_W]), .in_req(req),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red_level(m_red_level), .m_green_level(m_green_level),
        .m_blue_level(m_blue_level)
    );

    // remainder of the ramp divide is always below the section size
    a_ramp_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid[RAMP_W] |-> (ramp_rem < DVD_W'(sec_reg)))
        else $error("ramp divide remainder not below section size");

    a_section: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(sec_reg) * 32'(SECTIONS) <= 32'(cyc_reg)) &&
        (32'(cyc_reg) < 32'(sec_reg) * 32'(SECTIONS) + 32'(SECTIONS)))
        else $error("section size does not match cycle length");

    a_full_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_red_level == LEVEL_W'(LEVEL_MAX) ||
                     m_green_level == LEVEL_W'(LEVEL_MAX) ||
                     m_blue_level == LEVEL_W'(LEVEL_MAX) ||
                     (m_red_level == '0 && m_green_level == '0 && m_blue_level == '0)))
        else $error("lit word without a full channel");

    a_dark_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_red_level == '0 || m_green_level == '0 || m_blue_level == '0))
        else $error("word without a dark channel");

endmodule

FILE: src/hwrg_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwrg_div_cell
// One restoring division cell: tries divisor << SHIFT, shifts the bit in.
// ----------------------------------------------------------------------------
module hwrg_div_cell #(
    parameter int REM_W = 16,
    parameter int DIV_W = 16,
    parameter int ACC_W = 2,
    parameter int SHIFT = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [REM_W-1:0] in_rem,
    input  logic [ACC_W-1:0] in_acc,
    input  logic [DIV_W-1:0] divisor,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [REM_W-1:0] out_rem,
    output logic [ACC_W-1:0] out_acc
);

    localparam int CMP_W = REM_W + DIV_W;

    logic             valid_reg;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CMP_W-1:0] rem_ext, div_sh, diff;
    logic             fits;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        rem_ext  = CMP_W'(in_rem);
        div_sh   = CMP_W'(divisor) << SHIFT;
        fits     = rem_ext >= div_sh;
        diff     = rem_ext - div_sh;
        rem_next = fits ? REM_W'(diff) : in_rem;
        acc_next = {in_acc[ACC_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_acc   = acc_reg;

endmodule

FILE: src/hwrg_scale_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwrg_scale_stage
// Two stages: position times 255 for the ramp divide, strobe phase check.
// ----------------------------------------------------------------------------
module hwrg_scale_stage
    import hwrg_pkg::*;
#(
    parameter int POS_W              = 16,
    parameter int STROBE_HALF_PERIOD = STROBE_HALF_PERIOD_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               strobe_en,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [POS_W-1:0]   in_pos,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [POS_W+7:0]   out_dividend,
    output logic               out_lit
);

    localparam int DVD_W   = POS_W + 8;
    localparam int MOD     = 2 * STROBE_HALF_PERIOD;
    localparam int MOD_W   = 8;
    localparam int THR     = 3 * STROBE_HALF_PERIOD;
    localparam int K       = POS_W + 8;
    localparam longint unsigned RECIP = ((64'd1 << K) + 64'(MOD) - 64'd1) / 64'(MOD);
    localparam int RECIP_W = K + 1;
    localparam int PROD_W  = POS_W + RECIP_W;
    localparam int QM_W    = POS_W + MOD_W;

    logic              v1_reg, v2_reg, r1, r2;
    logic [POS_W-1:0]  pos1_reg, qm1_reg, qm_next;
    logic [DVD_W-1:0]  dvd1_reg, dvd2_reg, dvd_next;
    logic [PROD_W-1:0] prod_rcp;
    logic [QM_W-1:0]   qm_mod;
    logic [POS_W-1:0]  sp_wide;
    logic [MOD_W-1:0]  sp;
    logic              lit_next, lit2_reg;

    assign r2       = !v2_reg || out_ready;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_comb begin
        prod_rcp = PROD_W'(in_pos) * PROD_W'(RECIP);
        qm_next  = POS_W'(prod_rcp >> K);
        dvd_next = {in_pos, 8'b0} - DVD_W'(in_pos);
        qm_mod   = QM_W'(qm1_reg) * QM_W'(MOD);
        sp_wide  = pos1_reg - POS_W'(qm_mod);
        sp       = sp_wide[MOD_W-1:0];
        lit_next = !strobe_en || ({sp, 1'b0} > (MOD_W + 1)'(THR));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= in_valid;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r1) begin
            pos1_reg <= in_pos;
            qm1_reg  <= qm_next;
            dvd1_reg <= dvd_next;
        end
        if (r2) begin
            dvd2_reg <= dvd1_reg;
            lit2_reg <= lit_next;
        end
    end

    assign out_valid    = v2_reg;
    assign out_dividend = dvd2_reg;
    assign out_lit      = lit2_reg;

endmodule

FILE: src/hwrg_color_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwrg_color_stage
// Section select, ramp clamp and the output register.
// ----------------------------------------------------------------------------
module hwrg_color_stage
    import hwrg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  color_req_t         in_req,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEVEL_W-1:0] m_red_level,
    output logic [LEVEL_W-1:0] m_green_level,
    output logic [LEVEL_W-1:0] m_blue_level
);

    localparam int RW = RAMP_W + 2;

    logic               valid_reg;
    logic [LEVEL_W-1:0] red_reg, green_reg, blue_reg;
    logic [LEVEL_W-1:0] red_next, green_next, blue_next;
    logic [RAMP_W-1:0]  rb;
    logic [SEC_W-1:0]   idx, knot;
    logic [RW-1:0]      origin;
    logic signed [RW-1:0] ramp;
    logic [LEVEL_W-1:0] lvl;

    assign in_ready = !valid_reg || m_ready;
    assign rb       = in_req.ramp_base;

    always_comb begin
        if (rb >= RAMP_W'(5 * LEVEL_MAX)) begin
            idx = SEC_RB;
        end else if (rb >= RAMP_W'(4 * LEVEL_MAX)) begin
            idx = SEC_BR;
        end else if (rb >= RAMP_W'(3 * LEVEL_MAX)) begin
            idx = SEC_BG;
        end else if (rb >= RAMP_W'(2 * LEVEL_MAX)) begin
            idx = SEC_GB;
        end else if (rb >= RAMP_W'(LEVEL_MAX)) begin
            idx = SEC_GR;
        end else begin
            idx = SEC_RG;
        end

        knot   = idx[0] ? idx + SEC_W'(1) : idx;
        origin = RW'(LEVEL_MAX) * RW'(knot);
        ramp   = idx[0] ? $signed(origin - RW'(rb)) : $signed(RW'(rb) - origin);

        if (ramp < 0) begin
            lvl = '0;
        end else if (ramp > RW'(LEVEL_MAX)) begin
            lvl = LEVEL_W'(LEVEL_MAX);
        end else begin
            lvl = ramp[LEVEL_W-1:0];
        end

        unique case (idx)
            SEC_RG: begin
                red_next = LEVEL_W'(LEVEL_MAX); green_next = lvl; blue_next = '0;
            end
            SEC_GR: begin
                red_next = lvl; green_next = LEVEL_W'(LEVEL_MAX); blue_next = '0;
            end
            SEC_GB: begin
                red_next = '0; green_next = LEVEL_W'(LEVEL_MAX); blue_next = lvl;
            end
            SEC_BG: begin
                red_next = '0; green_next = lvl; blue_next = LEVEL_W'(LEVEL_MAX);
            end
            SEC_BR: begin
                red_next = lvl; green_next = '0; blue_next = LEVEL_W'(LEVEL_MAX);
            end
            default: begin
                red_next = LEVEL_W'(LEVEL_MAX); green_next = '0; blue_next = lvl;
            end
        endcase

        if (!in_req.lit) begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_red_level   = red_reg;
    assign m_green_level = green_reg;
    assign m_blue_level  = blue_reg;

endmodule
